// ===== hw/rtl/cycle_budget_throttle_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Cycle budget throttle unit: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef CYCLE_BUDGET_THROTTLE_UNIT_MACROS_SVH
`define CYCLE_BUDGET_THROTTLE_UNIT_MACROS_SVH

// same-cycle implication
`define CBT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication
`define CBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

// ===== hw/rtl/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Cycle budget throttle package
// Widths, codes, register map, state type and budget saturation.
// ----------------------------------------------------------------------------
package cbt_pkg;

	localparam int FRAC_BITS     = 16;
	localparam int ACC_WIDTH_DEF = 32;

	localparam int FUNC_W    = 3;
	localparam int US_W      = 20;
	localparam int CYCLES_W  = 16;
	localparam int RATE_IN_W = 32;
	localparam int SPEED_W   = 16;
	localparam int MINC_W    = 8;
	localparam int WAKE_W    = 32;
	localparam int SLICE_W   = 32;
	localparam int DATA_W    = 32;
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = 3;

	localparam int SPEED_FRAC = 8;
	localparam logic [SPEED_W-1:0] SPEED_ONE = SPEED_W'(256);

	localparam int BUDGET_W = 48;
	localparam int DEBT_W   = 47;
	localparam int RATE_W   = 40;
	localparam int MUL_A_W  = RATE_W;
	localparam int MUL_B_W  = US_W;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W  = BUDGET_W;
	localparam int DIV_D_W  = RATE_W;
	localparam int THR_W    = MUL_P_W + 1 - FRAC_BITS;
	localparam int NB_W     = MUL_P_W + 2;

	localparam logic signed [NB_W-1:0] BUDGET_MAX = NB_W'({DEBT_W{1'b1}});

	localparam logic [FUNC_W-1:0] FUNC_ADVANCE     = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_CHARGE      = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_BEGIN_SLICE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_RECORD      = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_STEP        = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_RESTART     = 3'd5;

	localparam int RUN_THROTTLED = 0;
	localparam int RUN_PAUSED    = 1;

	localparam logic [REG_IDX_W-1:0] REG_BASE_RATE     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SPEED_MULT    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RUN_MODE      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MIN_CYCLES    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CATCH_UP_US   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_EXEC_SLICE_US = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SERV_SLICE_US = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_MIN_SLEEP_US  = 3'd7;

	typedef struct packed {
		logic [RATE_IN_W-1:0] base_rate;
		logic [SPEED_W-1:0]   speed_mult;
		logic [1:0]           run_mode;
		logic [MINC_W-1:0]    min_cycles;
		logic [US_W-1:0]      catch_up_us;
		logic [US_W-1:0]      exec_slice_us;
		logic [US_W-1:0]      serv_slice_us;
		logic [US_W-1:0]      min_sleep_us;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RATE,
		ST_RATE_W,
		ST_DISPATCH,
		ST_ADV_P1,
		ST_ADV_P1_W,
		ST_ADV_P2,
		ST_ADV_P2_W,
		ST_ADV_CAP,
		ST_THR_EX,
		ST_THR_EX_W,
		ST_THR_SV,
		ST_THR_SV_W,
		ST_REC,
		ST_WAKE,
		ST_WAKE_W,
		ST_EMIT
	} state_t;

	function automatic logic signed [BUDGET_W-1:0] sat_budget(input logic signed [NB_W-1:0] v);
		if (v > BUDGET_MAX) begin
			return BUDGET_MAX[BUDGET_W-1:0];
		end else if (v < -BUDGET_MAX) begin
			return -BUDGET_MAX[BUDGET_W-1:0];
		end
		return v[BUDGET_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/cycle_budget_throttle_unit.sv =====
// ----------------------------------------------------------------------------
// Cycle budget throttle unit
// Token-bucket pacing of emulated execution with a signed Q32.16 budget.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid/item_stall carries func, elapsed_us and cycles.
//   One result per item leaves on result_valid/result_stall, held in an
//   output register; the next item is taken while a result still waits.
//   Registers are to be written over the APB-style port only while the
//   block is idle; the block itself does not enforce this. Every item
//   first forms the effective rate on the serial multiplier. An advance
//   that is not paused adds two more 20-bit serial multiplies, a record
//   item adds two for its thresholds, and an item that leaves the budget
//   short while throttled and not paused runs the 48-bit serial divider
//   for the wait. One item is in flight at a time, and the shared
//   multiplier and divider set how fast items go through.
//   Reset clears the budget, slice counters, step request and result valid,
//   and loads the register defaults. A stalled result holds its value, and
//   a finished item waits in its last state until the output register frees.
// ----------------------------------------------------------------------------
module cycle_budget_throttle_unit import cbt_pkg::*; #(
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [PADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]          pwdata,
	output logic [DATA_W-1:0]          prdata,
	output logic                       pready,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [FUNC_W-1:0]          func,
	input  logic [US_W-1:0]            elapsed_us,
	input  logic [CYCLES_W-1:0]        cycles,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic                       can_execute,
	output logic signed [BUDGET_W-1:0] cycle_budget,
	output logic [DEBT_W-1:0]          cycle_debt,
	output logic [SLICE_W-1:0]         slice_cycles,
	output logic                       slice_complete,
	output logic                       service_due,
	output logic                       budget_clamped,
	output logic                       step_granted,
	output logic [WAKE_W-1:0]          wake_after_us
);

	localparam int CMP_W = (ACC_WIDTH > THR_W) ? ACC_WIDTH : THR_W;
	localparam int SX_W  = (ACC_WIDTH > SLICE_W) ? ACC_WIDTH : SLICE_W;
	localparam logic [MUL_P_W:0] ROUND = (MUL_P_W + 1)'((64'd1 << FRAC_BITS) - 64'd1);

	cfg_t   cfg;
	state_t state_q, state_d;

	logic                 throttled, paused;
	logic [SPEED_W-1:0]   m_eff;
	logic [US_W-1:0]      ex_us, sv_us;

	logic                 mul_start, mul_busy;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [MUL_P_W-1:0]   mul_prod;
	logic                 div_start, div_busy;
	logic [DIV_N_W-1:0]   div_quot;

	logic [FUNC_W-1:0]    func_q;
	logic [US_W-1:0]      elapsed_q;
	logic [CYCLES_W-1:0]  cycles_q;
	logic [RATE_W-1:0]    rate_q;
	logic [MUL_P_W-1:0]   p1_q, cap_q;
	logic signed [NB_W-1:0] nb_q;
	logic [THR_W-1:0]     thr_ex_q, thr_sv_q;
	logic complete_q, due_q, clamped_q, granted_q;
	logic [WAKE_W-1:0]    wake_q;

	logic signed [BUDGET_W-1:0] budget_q;
	logic [ACC_WIDTH-1:0] exec_acc_q, serv_acc_q;
	logic                 step_pending_q;
	logic                 result_valid_q;

	logic                       can_execute_q;
	logic signed [BUDGET_W-1:0] cycle_budget_q;
	logic [DEBT_W-1:0]          cycle_debt_q;
	logic [SLICE_W-1:0]         slice_cycles_q;
	logic complete_out_q, due_out_q, clamped_out_q, granted_out_q;
	logic [WAKE_W-1:0]          wake_out_q;

	logic signed [BUDGET_W-1:0] minq;
	logic signed [NB_W-1:0]     budget_ext;
	logic [CYCLES_W-1:0]        charge_c;
	logic signed [NB_W-1:0]     charge_nb;
	logic signed [BUDGET_W-1:0] charge_budget;
	logic [MUL_P_W-1:0]         cap_cur;
	logic                       adv_over;
	logic signed [BUDGET_W-1:0] adv_budget;
	logic [MUL_P_W:0]           thr_round;
	logic [THR_W-1:0]           thr_raw, thr_cur;
	logic [ACC_WIDTH:0]         exec_sum, serv_sum;
	logic [ACC_WIDTH-1:0]       exec_new, serv_new;
	logic                       exec_hit, serv_hit;
	logic                       wake_cond;
	logic signed [BUDGET_W:0]   deficit_full;
	logic [WAKE_W-1:0]          wake_cur;
	logic                       out_free;
	logic signed [BUDGET_W-1:0] budget_neg;
	logic [SX_W-1:0]            exec_x;

	cbt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cbt_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.busy    (mul_busy),
		.product (mul_prod)
	);

	cbt_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (deficit_full[BUDGET_W-1:0]),
		.divisor  (rate_q),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	assign throttled = cfg.run_mode[RUN_THROTTLED];
	assign paused    = cfg.run_mode[RUN_PAUSED];
	assign m_eff     = (cfg.speed_mult == '0) ? SPEED_ONE : cfg.speed_mult;
	assign ex_us     = (cfg.exec_slice_us == '0) ? US_W'(1) : cfg.exec_slice_us;
	assign sv_us     = (cfg.serv_slice_us == '0) ? ex_us : cfg.serv_slice_us;
	assign out_free  = !result_valid_q || !result_stall;

	assign minq       = $signed(BUDGET_W'({cfg.min_cycles, {FRAC_BITS{1'b0}}}));
	assign budget_ext = $signed({{(NB_W - BUDGET_W){budget_q[BUDGET_W-1]}}, budget_q});

	// charge
	always_comb begin
		charge_c  = (cycles_q > CYCLES_W'(cfg.min_cycles)) ? cycles_q : CYCLES_W'(cfg.min_cycles);
		charge_nb = budget_ext - $signed(NB_W'({charge_c, {FRAC_BITS{1'b0}}}));
		if ((!throttled || paused) && charge_nb < 0) begin
			charge_nb = '0;
		end
		charge_budget = sat_budget(charge_nb);
	end

	// advance
	assign cap_cur    = (mul_prod < MUL_P_W'(unsigned'(minq))) ? MUL_P_W'(unsigned'(minq))
			: mul_prod;
	assign adv_over   = nb_q > $signed({2'b00, cap_q});
	assign adv_budget = sat_budget(adv_over ? $signed({2'b00, cap_q}) : nb_q);

	// slice thresholds
	assign thr_round = {1'b0, mul_prod} + ROUND;
	assign thr_raw   = thr_round[MUL_P_W:FRAC_BITS];
	assign thr_cur   = (thr_raw < THR_W'(cfg.min_cycles)) ? THR_W'(cfg.min_cycles) : thr_raw;

	// record
	assign exec_sum = {1'b0, exec_acc_q} + (ACC_WIDTH + 1)'(cycles_q);
	assign serv_sum = {1'b0, serv_acc_q} + (ACC_WIDTH + 1)'(cycles_q);
	assign exec_new = exec_sum[ACC_WIDTH] ? '1 : exec_sum[ACC_WIDTH-1:0];
	assign serv_new = serv_sum[ACC_WIDTH] ? '1 : serv_sum[ACC_WIDTH-1:0];
	assign exec_hit = CMP_W'(exec_new) >= CMP_W'(thr_ex_q);
	assign serv_hit = CMP_W'(serv_new) >= CMP_W'(thr_sv_q);

	// wait time
	assign wake_cond    = throttled && !paused && (rate_q != '0) && (budget_q < minq);
	assign deficit_full = {minq[BUDGET_W-1], minq} - {budget_q[BUDGET_W-1], budget_q};
	assign wake_cur     = (div_quot < DIV_N_W'(cfg.min_sleep_us)) ? '0
			: (|div_quot[DIV_N_W-1:WAKE_W]) ? '1 : div_quot[WAKE_W-1:0];

	assign budget_neg = -budget_q;
	assign exec_x     = SX_W'(exec_acc_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (item_valid) state_d = ST_RATE;
			ST_RATE:     state_d = ST_RATE_W;
			ST_RATE_W:   if (!mul_busy) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				case (func_q)
					FUNC_ADVANCE: state_d = paused ? ST_WAKE : ST_ADV_P1;
					FUNC_RECORD:  state_d = ST_THR_EX;
					default:      state_d = ST_WAKE;
				endcase
			end
			ST_ADV_P1:   state_d = ST_ADV_P1_W;
			ST_ADV_P1_W: if (!mul_busy) state_d = ST_ADV_P2;
			ST_ADV_P2:   state_d = ST_ADV_P2_W;
			ST_ADV_P2_W: if (!mul_busy) state_d = ST_ADV_CAP;
			ST_ADV_CAP:  state_d = ST_WAKE;
			ST_THR_EX:   state_d = ST_THR_EX_W;
			ST_THR_EX_W: if (!mul_busy) state_d = ST_THR_SV;
			ST_THR_SV:   state_d = ST_THR_SV_W;
			ST_THR_SV_W: if (!mul_busy) state_d = ST_REC;
			ST_REC:      state_d = ST_WAKE;
			ST_WAKE:     state_d = wake_cond ? ST_WAKE_W : ST_EMIT;
			ST_WAKE_W:   if (!div_busy) state_d = ST_EMIT;
			ST_EMIT:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		item_stall = 1'b1;
		mul_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		div_start  = 1'b0;
		case (state_q)
			ST_IDLE: item_stall = 1'b0;
			ST_RATE: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(cfg.base_rate);
				mul_b     = MUL_B_W'(m_eff);
			end
			ST_ADV_P1: begin
				mul_start = 1'b1;
				mul_a     = rate_q;
				mul_b     = elapsed_q;
			end
			ST_ADV_P2: begin
				mul_start = 1'b1;
				mul_a     = rate_q;
				mul_b     = cfg.catch_up_us;
			end
			ST_THR_EX: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(cfg.base_rate);
				mul_b     = ex_us;
			end
			ST_THR_SV: begin
				mul_start = 1'b1;
				mul_a     = MUL_A_W'(cfg.base_rate);
				mul_b     = sv_us;
			end
			ST_WAKE: div_start = wake_cond;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			budget_q       <= '0;
			exec_acc_q     <= '0;
			serv_acc_q     <= '0;
			step_pending_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (result_valid_q && !result_stall && state_q != ST_EMIT) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_DISPATCH: begin
					case (func_q)
						FUNC_CHARGE: begin
							budget_q <= charge_budget;
							if (paused) begin
								step_pending_q <= 1'b0;
							end
						end
						FUNC_BEGIN_SLICE: exec_acc_q <= '0;
						FUNC_STEP:        step_pending_q <= 1'b1;
						FUNC_RESTART: begin
							budget_q   <= '0;
							exec_acc_q <= '0;
							serv_acc_q <= '0;
						end
						default: ;
					endcase
				end
				ST_ADV_CAP: budget_q <= adv_budget;
				ST_REC: begin
					exec_acc_q <= exec_new;
					serv_acc_q <= serv_hit ? '0 : serv_new;
				end
				ST_EMIT: if (out_free) result_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					func_q     <= func;
					elapsed_q  <= elapsed_us;
					cycles_q   <= cycles;
					complete_q <= 1'b0;
					due_q      <= 1'b0;
					clamped_q  <= 1'b0;
					granted_q  <= 1'b0;
					wake_q     <= '0;
				end
			end
			ST_RATE_W:   if (!mul_busy) rate_q <= mul_prod[SPEED_FRAC +: RATE_W];
			ST_DISPATCH: if (func_q == FUNC_CHARGE) granted_q <= paused && step_pending_q;
			ST_ADV_P1_W: if (!mul_busy) p1_q <= mul_prod;
			ST_ADV_P2_W: begin
				if (!mul_busy) begin
					nb_q  <= budget_ext + $signed({2'b00, p1_q});
					cap_q <= cap_cur;
				end
			end
			ST_ADV_CAP:  clamped_q <= adv_over;
			ST_THR_EX_W: if (!mul_busy) thr_ex_q <= thr_cur;
			ST_THR_SV_W: if (!mul_busy) thr_sv_q <= thr_cur;
			ST_REC: begin
				complete_q <= exec_hit;
				due_q      <= serv_hit;
			end
			ST_WAKE_W:   if (!div_busy) wake_q <= wake_cur;
			ST_EMIT: begin
				if (out_free) begin
					if (paused) begin
						can_execute_q <= step_pending_q;
					end else if (!throttled) begin
						can_execute_q <= 1'b1;
					end else begin
						can_execute_q <= budget_q >= minq;
					end
					cycle_budget_q <= budget_q;
					cycle_debt_q   <= budget_q[BUDGET_W-1] ? budget_neg[DEBT_W-1:0] : '0;
					slice_cycles_q <= (exec_x > SX_W'({SLICE_W{1'b1}})) ? '1
							: exec_x[SLICE_W-1:0];
					complete_out_q <= complete_q;
					due_out_q      <= due_q;
					clamped_out_q  <= clamped_q;
					granted_out_q  <= granted_q;
					wake_out_q     <= wake_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid   = result_valid_q;
	assign can_execute    = can_execute_q;
	assign cycle_budget   = cycle_budget_q;
	assign cycle_debt     = cycle_debt_q;
	assign slice_cycles   = slice_cycles_q;
	assign slice_complete = complete_out_q;
	assign service_due    = due_out_q;
	assign budget_clamped = clamped_out_q;
	assign step_granted   = granted_out_q;
	assign wake_after_us  = wake_out_q;

endmodule

// ===== hw/rtl/cbt_mul.sv =====
// ----------------------------------------------------------------------------
// Cycle budget throttle: serial multiplier
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cbt_mul import cbt_pkg::*; #(
	parameter int A_W = MUL_A_W,
	parameter int B_W = MUL_B_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               busy,
	output logic [A_W+B_W-1:0] product
);

	localparam int CNT_W = $clog2(B_W);

	logic               run_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [A_W-1:0]     a_q;
	logic [A_W+B_W-1:0] p_q;
	logic [A_W:0]       sum;

	assign sum = {1'b0, p_q[A_W+B_W-1:B_W]} + (p_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(B_W - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{A_W{1'b0}}, b};
		end else if (run_q) begin
			p_q <= {sum, p_q[B_W-1:1]};
		end
	end

	assign busy    = run_q;
	assign product = p_q;

endmodule

// ===== hw/rtl/cbt_div.sv =====
// ----------------------------------------------------------------------------
// Cycle budget throttle: serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbt_div import cbt_pkg::*; #(
	parameter int N_W = DIV_N_W,
	parameter int D_W = DIV_D_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output logic           busy,
	output logic [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W);

	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   d_q;
	logic [D_W-1:0]   rem_q;
	logic [N_W-1:0]   q_q;
	logic [D_W:0]     trial;
	logic [D_W+1:0]   diff;
	logic             ge;

	assign trial = {rem_q, q_q[N_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, d_q};
	assign ge    = !diff[D_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(N_W - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= divisor;
			rem_q <= '0;
			q_q   <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
			q_q   <= {q_q[N_W-2:0], ge};
		end
	end

	assign busy     = run_q;
	assign quotient = q_q;

endmodule

// ===== hw/rtl/cbt_regs.sv =====
// ----------------------------------------------------------------------------
// Cycle budget throttle: configuration registers
// APB-style register file with read-back; one 32-bit word per register.
// ----------------------------------------------------------------------------
module cbt_regs import cbt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_rate     <= RATE_IN_W'(65536);
			cfg_q.speed_mult    <= SPEED_ONE;
			cfg_q.run_mode      <= 2'b01;
			cfg_q.min_cycles    <= MINC_W'(4);
			cfg_q.catch_up_us   <= US_W'(100000);
			cfg_q.exec_slice_us <= US_W'(1000);
			cfg_q.serv_slice_us <= '0;
			cfg_q.min_sleep_us  <= US_W'(1000);
		end else if (wr_en) begin
			case (idx)
				REG_BASE_RATE:     cfg_q.base_rate     <= pwdata[RATE_IN_W-1:0];
				REG_SPEED_MULT:    cfg_q.speed_mult    <= pwdata[SPEED_W-1:0];
				REG_RUN_MODE:      cfg_q.run_mode      <= pwdata[1:0];
				REG_MIN_CYCLES:    cfg_q.min_cycles    <= pwdata[MINC_W-1:0];
				REG_CATCH_UP_US:   cfg_q.catch_up_us   <= pwdata[US_W-1:0];
				REG_EXEC_SLICE_US: cfg_q.exec_slice_us <= pwdata[US_W-1:0];
				REG_SERV_SLICE_US: cfg_q.serv_slice_us <= pwdata[US_W-1:0];
				REG_MIN_SLEEP_US:  cfg_q.min_sleep_us  <= pwdata[US_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BASE_RATE:     prdata = DATA_W'(cfg_q.base_rate);
			REG_SPEED_MULT:    prdata = DATA_W'(cfg_q.speed_mult);
			REG_RUN_MODE:      prdata = DATA_W'(cfg_q.run_mode);
			REG_MIN_CYCLES:    prdata = DATA_W'(cfg_q.min_cycles);
			REG_CATCH_UP_US:   prdata = DATA_W'(cfg_q.catch_up_us);
			REG_EXEC_SLICE_US: prdata = DATA_W'(cfg_q.exec_slice_us);
			REG_SERV_SLICE_US: prdata = DATA_W'(cfg_q.serv_slice_us);
			REG_MIN_SLEEP_US:  prdata = DATA_W'(cfg_q.min_sleep_us);
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/cbt_checker.sv =====
// ----------------------------------------------------------------------------
// Cycle budget throttle: port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "cycle_budget_throttle_unit_macros.svh"

module cbt_checker import cbt_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_stall,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic signed [BUDGET_W-1:0] cycle_budget,
	input logic [DEBT_W-1:0]          cycle_debt,
	input logic                       slice_complete,
	input logic                       service_due,
	input logic                       budget_clamped,
	input logic                       step_granted
);

	`CBT_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(cycle_budget))
	`CBT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && !item_stall, item_stall)
	`CBT_ASSERT_SAME(a_debt_zero, clk, arst_n, result_valid && !cycle_budget[BUDGET_W-1], cycle_debt == '0)
	`CBT_ASSERT_SAME(a_debt_set, clk, arst_n, result_valid && cycle_budget[BUDGET_W-1], cycle_debt != '0)
	`CBT_ASSERT_SAME(a_flag_excl, clk, arst_n, result_valid, $countones({budget_clamped, step_granted, slice_complete || service_due}) <= 1)

endmodule

bind cycle_budget_throttle_unit cbt_checker u_cbt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_stall     (item_stall),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.cycle_budget   (cycle_budget),
	.cycle_debt     (cycle_debt),
	.slice_complete (slice_complete),
	.service_due    (service_due),
	.budget_clamped (budget_clamped),
	.step_granted   (step_granted)
);
